>>> src/mhpq_pkg.sv
// Package for the min-heap priority queue: command and status codes.
// No dependencies; used by the result interface and imported by the top level.
package mhpq_pkg;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PUSH_FULL = 2'd1,
    ST_POP_EMPTY = 2'd2
  } status_e;

endpackage

>>> src/mhpq_cmd_if.sv
// Command channel of the min-heap priority queue: valid/ready plus one item.
// Depends on nothing but its parameter.
interface mhpq_cmd_if #(
  parameter int VALUE_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

>>> src/mhpq_res_if.sv
// Result channel of the min-heap priority queue: valid/ready plus one item.
// Uses mhpq_pkg for the status code type.
interface mhpq_res_if #(
  parameter int VALUE_BITS = 32,
  parameter int COUNT_BITS = 7
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] removed_value;
  logic signed [VALUE_BITS-1:0] min_value;
  logic        [COUNT_BITS-1:0] entry_count;
  logic                         is_empty;
  logic                         is_full;
  mhpq_pkg::status_e            status;

  modport source (output valid, removed_value, min_value, entry_count, is_empty, is_full,
                  status, input ready);
  modport sink   (input valid, removed_value, min_value, entry_count, is_empty, is_full,
                  status, output ready);
endinterface

>>> src/min_heap_priority_queue.sv
// Min-heap priority queue: sequencer around one heap RAM and one shared comparator.
// Push climbs from the new leaf: read the parent and move it down while the new value is
// smaller. Pop puts the last entry at the root and descends: read both children, pick the
// smaller (left on a tie) and move it up while it is below that entry; refusals go to FIN.
// One item at a time, taken in idle; FIN holds while the result is unread.
// Reset clears the entry count; the heap RAM is not initialised and needs no clearing pass.
module min_heap_priority_queue #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mhpq_cmd_if.sink  cmd_i,
  mhpq_res_if.source res_o
);
  import mhpq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int WIDE  = IDX_W + 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_RD,
    S_DN_SEL,
    S_DN_CMP,
    S_FIN
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       pos_q, pos_d;
  logic [IDX_W-1:0]       pick_q, pick_d;
  logic                   rc_ok_q, rc_ok_d;
  logic [VALUE_BITS-1:0]  cur_q, cur_d;
  logic [VALUE_BITS-1:0]  pval_q, pval_d;
  logic [VALUE_BITS-1:0]  root_q, root_d;
  logic [VALUE_BITS-1:0]  removed_q, removed_d;
  status_e                stat_q, stat_d;

  logic                   out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0]  out_removed_q, out_removed_d;
  logic [VALUE_BITS-1:0]  out_min_q, out_min_d;
  logic [CNT_W-1:0]       out_cnt_q, out_cnt_d;
  logic                   out_empty_q, out_empty_d;
  logic                   out_full_q, out_full_d;
  status_e                out_stat_q, out_stat_d;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [VALUE_BITS-1:0]  ram_wdata;
  logic [IDX_W-1:0]       ram_raddr0, ram_raddr1;
  logic [VALUE_BITS-1:0]  rd0, rd1;

  logic [VALUE_BITS-1:0]  cmp_a, cmp_b;
  logic                   cmp_lt;

  logic [WIDE-1:0]        lc_w, rc_w, cnt_w;
  logic [IDX_W-1:0]       pos_m1, parent;
  logic                   is_full;

  mhpq_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr0_i(ram_raddr0),
    .raddr1_i(ram_raddr1),
    .rdata0_o(rd0),
    .rdata1_o(rd1)
  );

  // the one comparator, operands picked by the sequencer step
  always_comb begin
    unique case (state_q)
      S_UP_CMP: begin
        cmp_a = cur_q;
        cmp_b = rd0;
      end
      S_DN_SEL: begin
        cmp_a = rd1;
        cmp_b = rd0;
      end
      default: begin
        cmp_a = pval_q;
        cmp_b = cur_q;
      end
    endcase
  end
  assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

  assign lc_w    = {1'b0, pos_q, 1'b1};
  assign rc_w    = lc_w + WIDE'(1);
  assign cnt_w   = WIDE'(cnt_q);
  assign pos_m1  = pos_q - IDX_W'(1);
  assign parent  = pos_m1 >> 1;
  assign is_full = (cnt_q == CNT_W'(CAPACITY));

  assign cmd_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    pos_d         = pos_q;
    pick_d        = pick_q;
    rc_ok_d       = rc_ok_q;
    cur_d         = cur_q;
    pval_d        = pval_q;
    root_d        = root_q;
    removed_d     = removed_q;
    stat_d        = stat_q;
    out_valid_d   = out_valid_q;
    out_removed_d = out_removed_q;
    out_min_d     = out_min_q;
    out_cnt_d     = out_cnt_q;
    out_empty_d   = out_empty_q;
    out_full_d    = out_full_q;
    out_stat_d    = out_stat_q;
    ram_we        = 1'b0;
    ram_waddr     = pos_q;
    ram_wdata     = cur_q;
    ram_raddr0    = pos_q;
    ram_raddr1    = pos_q;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          removed_d = '0;
          stat_d    = ST_OK;
          if (cmd_i.command == CMD_PUSH) begin
            if (is_full) begin
              stat_d  = ST_PUSH_FULL;
              state_d = S_FIN;
            end else begin
              cur_d   = cmd_i.value;
              pos_d   = cnt_q[IDX_W-1:0];
              cnt_d   = cnt_q + CNT_W'(1);
              state_d = S_UP_RD;
            end
          end else begin
            if (cnt_q == '0) begin
              stat_d  = ST_POP_EMPTY;
              state_d = S_FIN;
            end else begin
              removed_d = root_q;
              pos_d     = IDX_W'(cnt_q - CNT_W'(1));
              cnt_d     = cnt_q - CNT_W'(1);
              state_d   = S_POP_RD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_FIN;
        end else begin
          ram_raddr0 = parent;
          state_d    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          // parent moves down, new value keeps climbing
          ram_wdata = rd0;
          pos_d     = parent;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_POP_RD: begin
        state_d = S_POP_LD;
      end
      S_POP_LD: begin
        cur_d   = rd0;
        pos_d   = '0;
        state_d = (cnt_q == '0) ? S_FIN : S_DN_RD;
      end
      S_DN_RD: begin
        if (lc_w >= cnt_w) begin
          ram_we  = 1'b1;
          state_d = S_FIN;
        end else begin
          ram_raddr0 = lc_w[IDX_W-1:0];
          ram_raddr1 = rc_w[IDX_W-1:0];
          rc_ok_d    = (rc_w < cnt_w);
          state_d    = S_DN_SEL;
        end
      end
      S_DN_SEL: begin
        // left child wins a tie
        if (rc_ok_q && cmp_lt) begin
          pick_d = rc_w[IDX_W-1:0];
          pval_d = rd1;
        end else begin
          pick_d = lc_w[IDX_W-1:0];
          pval_d = rd0;
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (cmp_lt) begin
          ram_wdata = pval_q;
          pos_d     = pick_q;
          state_d   = S_DN_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d   = 1'b1;
          out_removed_d = removed_q;
          out_min_d     = (cnt_q == '0) ? '0 : root_q;
          out_cnt_d     = cnt_q;
          out_empty_d   = (cnt_q == '0);
          out_full_d    = is_full;
          out_stat_d    = stat_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // the root is mirrored so the minimum needs no extra read
    if (ram_we && ram_waddr == '0) begin
      root_d = ram_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      pos_q         <= '0;
      pick_q        <= '0;
      rc_ok_q       <= 1'b0;
      cur_q         <= '0;
      pval_q        <= '0;
      root_q        <= '0;
      removed_q     <= '0;
      stat_q        <= ST_OK;
      out_valid_q   <= 1'b0;
      out_removed_q <= '0;
      out_min_q     <= '0;
      out_cnt_q     <= '0;
      out_empty_q   <= 1'b1;
      out_full_q    <= 1'b0;
      out_stat_q    <= ST_OK;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      pos_q         <= pos_d;
      pick_q        <= pick_d;
      rc_ok_q       <= rc_ok_d;
      cur_q         <= cur_d;
      pval_q        <= pval_d;
      root_q        <= root_d;
      removed_q     <= removed_d;
      stat_q        <= stat_d;
      out_valid_q   <= out_valid_d;
      out_removed_q <= out_removed_d;
      out_min_q     <= out_min_d;
      out_cnt_q     <= out_cnt_d;
      out_empty_q   <= out_empty_d;
      out_full_q    <= out_full_d;
      out_stat_q    <= out_stat_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.removed_value = out_removed_q;
  assign res_o.min_value     = out_min_q;
  assign res_o.entry_count   = out_cnt_q;
  assign res_o.is_empty      = out_empty_q;
  assign res_o.is_full       = out_full_q;
  assign res_o.status        = out_stat_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CNT_W'(ram_waddr) < cnt_q))
    else $error("heap write beyond the filled entries");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == ST_PUSH_FULL) |-> res_o.is_full)
    else $error("push refused while not full");

  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == ST_POP_EMPTY) |->
      (res_o.is_empty && res_o.removed_value == '0))
    else $error("pop refused while not empty");

endmodule

>>> src/mhpq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic [WIDTH-1:0]         rdata0_o,
  output logic [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule
